>>> design/pvrt_pkg.sv
// Shared types and constants of the path-vector route table.
// No dependencies; every design file refers to this package by scoped names.
package pvrt_pkg;

    localparam int ID_W      = 4;
    localparam int COST_W    = 10;
    localparam int PLEN_W    = 5;
    localparam int OP_W      = 3;
    localparam int CFG_IDX_W = 2;
    localparam int HOP_BUF   = 16;
    localparam int HOP_IDX_W = 4;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
    localparam logic [OP_W-1:0] OP_HDR   = 3'd2;
    localparam logic [OP_W-1:0] OP_HOP   = 3'd3;
    localparam logic [OP_W-1:0] OP_DOWN  = 3'd4;
    localparam logic [OP_W-1:0] OP_READ  = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MY_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INF   = 2'd1;

    localparam logic [COST_W-1:0] INF_RESET = 10'd999;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ID_W-1:0]   router_id;
        logic [ID_W-1:0]   dest_id;
        logic [COST_W-1:0] link_cost;
        logic [COST_W-1:0] advertised_cost;
        logic [ID_W-1:0]   path_length;
        logic [ID_W-1:0]   hop_id;
        logic [ID_W-1:0]   hop_index;
    } t_req;

    typedef struct packed {
        logic              route_changed;
        logic              entry_valid;
        logic [ID_W-1:0]   entry_next_hop;
        logic [COST_W-1:0] entry_cost;
        logic [PLEN_W-1:0] entry_path_length;
        logic [ID_W-1:0]   entry_hop;
    } t_rsp;

    // One word of the entry memory.
    typedef struct packed {
        logic [ID_W-1:0]   gateway;
        logic [COST_W-1:0] cost;
        logic [PLEN_W-1:0] span;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD2,
        ST_DN_RD,
        ST_DN_WR,
        ST_RD_OUT,
        ST_EVAL,
        ST_CMP_RD,
        ST_CMP_CHK,
        ST_COPY
    } t_state;

endpackage

>>> design/pvrt_path_ram.sv
// Hop path storage: one write port and one read port with registered data.
// Depends on pvrt_pkg for the id width.
module pvrt_path_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [pvrt_pkg::ID_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [pvrt_pkg::ID_W-1:0] o_rdata
);

    logic [pvrt_pkg::ID_W-1:0] r_mem [DEPTH];
    logic [pvrt_pkg::ID_W-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/path_vector_route_table.sv
// Path-vector route table: entry memory, hop path memory and the update sequencer.
// Depends on pvrt_pkg and pvrt_path_ram.
//
// Every accepted request produces exactly one result strobe; the receiver cannot
// stall, so results must be taken in the cycle they appear. Clear, route header,
// a path hop that is not the last, and unused codes keep the sequencer in ST_IDLE
// and the next request can follow immediately. Add neighbour (in-range id) and read
// pass through ST_ADD2 or ST_RD_OUT before the result. Neighbour down walks the entry
// memory with a read state and a write state per entry. The last path hop reads the
// entry and decides in ST_EVAL, then a forced update compares the stored path hop by
// hop (ST_CMP_RD, ST_CMP_CHK) and an installed path is copied in ST_COPY (stored
// hops = min(path_length, PATH_SLOTS-1)); the path memory has a single read port and
// a single write port. Configuration is always ready. No clearing pass.
module path_vector_route_table #(
    parameter int ROUTER_COUNT = 16,
    parameter int PATH_SLOTS   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  pvrt_pkg::t_req                 i_req,
    output logic                           o_strobe,
    output pvrt_pkg::t_rsp                 o_rsp,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pvrt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pvrt_pkg::COST_W-1:0]    i_cfg_data
);

    localparam int EW = $clog2(ROUTER_COUNT);
    localparam int PW = $clog2(ROUTER_COUNT * PATH_SLOTS);
    localparam logic [PW-1:0] PS_W = PW'(PATH_SLOTS);

    localparam int ID_W   = pvrt_pkg::ID_W;
    localparam int COST_W = pvrt_pkg::COST_W;
    localparam int PLEN_W = pvrt_pkg::PLEN_W;
    localparam int HIW    = pvrt_pkg::HOP_IDX_W;

    // Control state.
    pvrt_pkg::t_state r_state, n_state;
    logic [ID_W-1:0]         r_my_id;
    logic [COST_W-1:0]       r_inf;
    logic [ROUTER_COUNT-1:0] r_valid, n_valid;
    logic                    r_pend_active, n_pend_active;
    logic [PLEN_W-1:0]       r_hrcv, n_hrcv;
    logic                    r_self, n_self;
    logic                    r_strobe, n_strobe;

    // Payload state.
    logic [ID_W-1:0]   r_sender, n_sender;
    logic [ID_W-1:0]   r_dest, n_dest;
    logic [COST_W-1:0] r_link, n_link;
    logic [COST_W-1:0] r_adv, n_adv;
    logic [ID_W-1:0]   r_plen, n_plen;
    logic [ID_W-1:0]   r_hops [pvrt_pkg::HOP_BUF];
    logic [HIW-1:0]    r_k, n_k;
    logic [EW-1:0]     r_idx, n_idx;
    logic [ID_W-1:0]   r_rid, n_rid;
    logic [ID_W-1:0]   r_hix, n_hix;
    pvrt_pkg::t_rsp    r_rsp, n_rsp;

    // Entry memory.
    pvrt_pkg::t_entry r_ent_mem [ROUTER_COUNT];
    pvrt_pkg::t_entry r_ent_q;
    logic             ent_we;
    logic [EW-1:0]    ent_waddr, ent_raddr;
    pvrt_pkg::t_entry ent_wdata;

    // Path memory ports.
    logic            path_we;
    logic [PW-1:0]   path_waddr, path_raddr;
    logic [ID_W-1:0] path_wdata, path_q;

    // Hop buffer write.
    logic            hop_we;
    logic [HIW-1:0]  hop_waddr;

    // Route decision helpers.
    logic [COST_W:0]   sum_raw;
    logic [COST_W-1:0] sum_sat;
    logic [PLEN_W-1:0] slen;
    logic [HIW-1:0]    mhops;
    logic [EW-1:0]     d_idx;
    logic              req_acc;

    function automatic logic in_rng(input logic [ID_W-1:0] id);
        return 32'(id) < ROUTER_COUNT;
    endfunction

    function automatic logic [PW-1:0] paddr(input logic [EW-1:0] idx,
                                            input logic [PW-1:0] slot);
        return PW'(idx) * PS_W + slot;
    endfunction

    pvrt_path_ram #(
        .DEPTH (ROUTER_COUNT * PATH_SLOTS),
        .AW    (PW)
    ) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (path_we),
        .i_waddr (path_waddr),
        .i_wdata (path_wdata),
        .i_raddr (path_raddr),
        .o_rdata (path_q)
    );

    assign busy        = (r_state != pvrt_pkg::ST_IDLE);
    assign req_acc     = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_rsp       = r_rsp;

    // Saturated route cost, stored length and count of stored hops.
    assign sum_raw = {1'b0, r_adv} + {1'b0, r_link};
    assign sum_sat = (sum_raw >= {1'b0, r_inf}) ? r_inf : sum_raw[COST_W-1:0];
    assign slen    = (32'(r_plen) + 1 < PATH_SLOTS) ? (PLEN_W'(r_plen) + 5'd1)
                                                    : PLEN_W'(PATH_SLOTS);
    assign mhops   = (32'(r_plen) < PATH_SLOTS - 1) ? r_plen : HIW'(PATH_SLOTS - 1);
    assign d_idx   = EW'(r_dest);

    // Next state and memory control.
    always_comb begin
        logic do_install;
        do_install    = 1'b0;
        n_state       = r_state;
        n_valid       = r_valid;
        n_pend_active = r_pend_active;
        n_hrcv        = r_hrcv;
        n_self        = r_self;
        n_sender      = r_sender;
        n_dest        = r_dest;
        n_link        = r_link;
        n_adv         = r_adv;
        n_plen        = r_plen;
        n_k           = r_k;
        n_idx         = r_idx;
        n_rid         = r_rid;
        n_hix         = r_hix;
        n_strobe      = 1'b0;
        n_rsp         = '0;
        ent_we        = 1'b0;
        ent_waddr     = d_idx;
        ent_wdata     = '0;
        ent_raddr     = d_idx;
        path_we       = 1'b0;
        path_waddr    = '0;
        path_wdata    = r_my_id;
        path_raddr    = '0;
        hop_we        = 1'b0;
        hop_waddr     = r_hrcv[HIW-1:0];

        unique case (r_state)
            pvrt_pkg::ST_IDLE: begin
                if (req_acc) begin
                    unique case (i_req.operation)
                        pvrt_pkg::OP_CLEAR: begin
                            n_valid       = '0;
                            n_pend_active = 1'b0;
                            n_hrcv        = '0;
                            n_self        = 1'b0;
                            if (in_rng(r_my_id)) begin
                                n_valid[EW'(r_my_id)] = 1'b1;
                                ent_we     = 1'b1;
                                ent_waddr  = EW'(r_my_id);
                                ent_wdata  = '{gateway: r_my_id, cost: '0,
                                               span: PLEN_W'(1)};
                                path_we    = 1'b1;
                                path_waddr = paddr(EW'(r_my_id), '0);
                            end
                            n_strobe = 1'b1;
                        end
                        pvrt_pkg::OP_ADD: begin
                            if (in_rng(i_req.router_id)) begin
                                n_valid[EW'(i_req.router_id)] = 1'b1;
                                ent_we     = 1'b1;
                                ent_waddr  = EW'(i_req.router_id);
                                ent_wdata  = '{gateway: i_req.router_id,
                                               cost: (i_req.link_cost >= r_inf) ?
                                                     r_inf : i_req.link_cost,
                                               span: PLEN_W'(2)};
                                path_we    = 1'b1;
                                path_waddr = paddr(EW'(i_req.router_id), '0);
                                n_rid      = i_req.router_id;
                                n_state    = pvrt_pkg::ST_ADD2;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        pvrt_pkg::OP_HDR: begin
                            n_pend_active = (i_req.path_length != '0);
                            n_sender      = i_req.router_id;
                            n_dest        = i_req.dest_id;
                            n_link        = i_req.link_cost;
                            n_adv         = i_req.advertised_cost;
                            n_plen        = i_req.path_length;
                            n_hrcv        = '0;
                            n_self        = 1'b0;
                            n_strobe      = 1'b1;
                        end
                        pvrt_pkg::OP_HOP: begin
                            if (r_pend_active) begin
                                hop_we = 1'b1;
                                n_self = r_self || (i_req.hop_id == r_my_id);
                                n_hrcv = r_hrcv + 5'd1;
                                if (n_hrcv >= {1'b0, r_plen}) begin
                                    n_pend_active = 1'b0;
                                    if (in_rng(r_dest)) begin
                                        n_state = pvrt_pkg::ST_EVAL;
                                    end else begin
                                        n_strobe = 1'b1;
                                    end
                                end else begin
                                    n_strobe = 1'b1;
                                end
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        pvrt_pkg::OP_DOWN: begin
                            n_rid   = i_req.router_id;
                            n_idx   = '0;
                            n_state = pvrt_pkg::ST_DN_RD;
                        end
                        pvrt_pkg::OP_READ: begin
                            ent_raddr  = EW'(i_req.router_id);
                            path_raddr = paddr(EW'(i_req.router_id),
                                               PW'(i_req.hop_index));
                            n_rid      = i_req.router_id;
                            n_hix      = i_req.hop_index;
                            n_state    = pvrt_pkg::ST_RD_OUT;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end

            // Second path slot of a neighbour entry.
            pvrt_pkg::ST_ADD2: begin
                path_we    = 1'b1;
                path_waddr = paddr(EW'(r_rid), PW'(1));
                path_wdata = r_rid;
                n_strobe   = 1'b1;
                n_state    = pvrt_pkg::ST_IDLE;
            end

            // Neighbour down sweep: read an entry, then mark it unreachable.
            pvrt_pkg::ST_DN_RD: begin
                ent_raddr = r_idx;
                n_state   = pvrt_pkg::ST_DN_WR;
            end
            pvrt_pkg::ST_DN_WR: begin
                if (r_valid[r_idx] && (r_ent_q.gateway == r_rid)) begin
                    ent_we    = 1'b1;
                    ent_waddr = r_idx;
                    ent_wdata = '{gateway: r_ent_q.gateway, cost: r_inf,
                                  span: r_ent_q.span};
                end
                if (32'(r_idx) == ROUTER_COUNT - 1) begin
                    n_strobe = 1'b1;
                    n_state  = pvrt_pkg::ST_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = pvrt_pkg::ST_DN_RD;
                end
            end

            // Read result from the registered memory outputs.
            pvrt_pkg::ST_RD_OUT: begin
                if (in_rng(r_rid) && r_valid[EW'(r_rid)]) begin
                    n_rsp.entry_valid       = 1'b1;
                    n_rsp.entry_next_hop    = r_ent_q.gateway;
                    n_rsp.entry_cost        = r_ent_q.cost;
                    n_rsp.entry_path_length = r_ent_q.span;
                    if (({1'b0, r_hix} < r_ent_q.span) &&
                        (32'(r_hix) < PATH_SLOTS)) begin
                        n_rsp.entry_hop = path_q;
                    end
                end
                n_strobe = 1'b1;
                n_state  = pvrt_pkg::ST_IDLE;
            end

            // Route rule on the stored entry.
            pvrt_pkg::ST_EVAL: begin
                if (!r_valid[d_idx]) begin
                    do_install = 1'b1;
                end else if (r_ent_q.gateway == r_sender) begin
                    if (r_self) begin
                        if (r_ent_q.cost != r_inf) begin
                            ent_we    = 1'b1;
                            ent_wdata = '{gateway: r_ent_q.gateway, cost: r_inf,
                                          span: r_ent_q.span};
                            n_rsp.route_changed = 1'b1;
                        end
                        n_strobe = 1'b1;
                        n_state  = pvrt_pkg::ST_IDLE;
                    end else if ((r_ent_q.cost != sum_sat) ||
                                 (r_ent_q.span != slen)) begin
                        do_install = 1'b1;
                    end else begin
                        n_k     = '0;
                        n_state = pvrt_pkg::ST_CMP_RD;
                    end
                end else if ((sum_sat < r_ent_q.cost) && !r_self) begin
                    do_install = 1'b1;
                end else begin
                    n_strobe = 1'b1;
                    n_state  = pvrt_pkg::ST_IDLE;
                end
            end

            // Forced update: compare stored hops one at a time.
            pvrt_pkg::ST_CMP_RD: begin
                path_raddr = paddr(d_idx, PW'(r_k) + PW'(1));
                n_state    = pvrt_pkg::ST_CMP_CHK;
            end
            pvrt_pkg::ST_CMP_CHK: begin
                if (path_q != r_hops[r_k]) begin
                    do_install = 1'b1;
                end else if (r_k == mhops - 4'd1) begin
                    n_strobe = 1'b1;
                    n_state  = pvrt_pkg::ST_IDLE;
                end else begin
                    n_k     = r_k + 4'd1;
                    n_state = pvrt_pkg::ST_CMP_RD;
                end
            end

            // Copy the pending hops into the path memory.
            pvrt_pkg::ST_COPY: begin
                path_we    = 1'b1;
                path_waddr = paddr(d_idx, PW'(r_k) + PW'(1));
                path_wdata = r_hops[r_k];
                if (r_k == mhops - 4'd1) begin
                    n_rsp.route_changed = 1'b1;
                    n_strobe            = 1'b1;
                    n_state             = pvrt_pkg::ST_IDLE;
                end else begin
                    n_k = r_k + 4'd1;
                end
            end

            default: begin
                n_state = pvrt_pkg::ST_IDLE;
            end
        endcase

        // Install the advertised route: entry word and first path slot here,
        // the remaining hops in the copy state.
        if (do_install) begin
            n_valid[d_idx] = 1'b1;
            ent_we         = 1'b1;
            ent_wdata      = '{gateway: r_sender, cost: sum_sat, span: slen};
            path_we        = 1'b1;
            path_waddr     = paddr(d_idx, '0);
            path_wdata     = r_my_id;
            n_k            = '0;
            n_state        = pvrt_pkg::ST_COPY;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= pvrt_pkg::ST_IDLE;
            r_my_id       <= '0;
            r_inf         <= pvrt_pkg::INF_RESET;
            r_valid       <= '0;
            r_pend_active <= 1'b0;
            r_hrcv        <= '0;
            r_self        <= 1'b0;
            r_strobe      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_valid       <= n_valid;
            r_pend_active <= n_pend_active;
            r_hrcv        <= n_hrcv;
            r_self        <= n_self;
            r_strobe      <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    pvrt_pkg::CFG_MY_ID: r_my_id <= i_cfg_data[ID_W-1:0];
                    pvrt_pkg::CFG_INF:   r_inf   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers and hop buffer.
    always_ff @(posedge i_clk) begin
        r_sender <= n_sender;
        r_dest   <= n_dest;
        r_link   <= n_link;
        r_adv    <= n_adv;
        r_plen   <= n_plen;
        r_k      <= n_k;
        r_idx    <= n_idx;
        r_rid    <= n_rid;
        r_hix    <= n_hix;
        r_rsp    <= n_rsp;
        if (hop_we) begin
            r_hops[hop_waddr] <= i_req.hop_id;
        end
    end

    // Entry memory with registered read.
    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_ent_mem[ent_waddr] <= ent_wdata;
        end
        r_ent_q <= r_ent_mem[ent_raddr];
    end

    // A reported change comes only out of the route decision states.
    a_changed_from_route: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.route_changed) |-> ($past(r_state) != pvrt_pkg::ST_IDLE))
        else $error("route change reported without a route decision");

    // The stored path is compared only for an existing entry.
    a_cmp_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pvrt_pkg::ST_CMP_CHK) |-> r_valid[d_idx])
        else $error("path compare on an empty entry");

    // Clear drops any pending route header.
    a_clear_drops_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && (i_req.operation == pvrt_pkg::OP_CLEAR)) |=> !r_pend_active)
        else $error("pending header survived a clear");

endmodule

>>> verif/path_vector_route_table_tb.sv
// Self-checking testbench for the path-vector route table.
// Depends on pvrt_pkg and path_vector_route_table; it holds its own table predictor.
`timescale 1ns / 1ps

module path_vector_route_table_tb;

    localparam int ID_W      = pvrt_pkg::ID_W;
    localparam int COST_W    = pvrt_pkg::COST_W;
    localparam int PLEN_W    = pvrt_pkg::PLEN_W;
    localparam int OP_W      = pvrt_pkg::OP_W;
    localparam int CFG_IDX_W = pvrt_pkg::CFG_IDX_W;
    localparam int HOP_BUF   = pvrt_pkg::HOP_BUF;

    localparam int IDS   = 16;
    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 600000;
    // Longest request: the last hop of a long forced update, or a neighbour-down sweep.
    localparam int SETTLE_CYCLES = 80;

    // Predictor of the route table and store of the results it expects.
    class route_scoreboard;
        logic [ID_W-1:0]   my_id;
        logic [COST_W-1:0] inf_cost;
        bit                valid_tab[IDS];
        logic [ID_W-1:0]   next_hop_tab[IDS];
        logic [COST_W-1:0] cost_tab[IDS];
        logic [PLEN_W-1:0] plen_tab[IDS];
        logic [ID_W-1:0]   path_tab[IDS][SLOTS];
        bit                pend_active;
        pvrt_pkg::t_req    pend;
        logic [ID_W-1:0]   pend_hops[HOP_BUF];
        int                hops_seen;
        bit                path_loops;
        pvrt_pkg::t_rsp    expected_q[$];
        int                mismatches;

        function new();
            my_id       = '0;
            inf_cost    = pvrt_pkg::INF_RESET;
            pend_active = 0;
            pend        = '0;
            hops_seen   = 0;
            path_loops  = 0;
            mismatches  = 0;
            foreach (valid_tab[i]) valid_tab[i] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COST_W-1:0] data);
            if (idx == pvrt_pkg::CFG_MY_ID) my_id = data[ID_W-1:0];
            else if (idx == pvrt_pkg::CFG_INF) inf_cost = data;
        endfunction

        function int kept_len(int n);
            return (n + 1 < SLOTS) ? n + 1 : SLOTS;
        endfunction

        function void store_path(int d, int n);
            path_tab[d][0] = my_id;
            for (int k = 0; k < n && k + 1 < SLOTS; k++) path_tab[d][k+1] = pend_hops[k];
            plen_tab[d] = PLEN_W'(kept_len(n));
        endfunction

        // Applies the pending route once its last hop is in; returns the changed flag.
        function bit apply_route();
            int d;
            int n;
            int sum;
            bit changed;
            d = pend.dest_id;
            n = pend.path_length;
            changed = 0;
            sum = pend.advertised_cost + pend.link_cost;
            if (sum >= inf_cost) sum = inf_cost;
            if (!valid_tab[d]) begin
                valid_tab[d]    = 1;
                next_hop_tab[d] = pend.router_id;
                cost_tab[d]     = COST_W'(sum);
                store_path(d, n);
                return 1;
            end
            if (next_hop_tab[d] == pend.router_id) begin
                if (path_loops) begin
                    if (cost_tab[d] != inf_cost) begin
                        cost_tab[d] = inf_cost;
                        return 1;
                    end
                    return 0;
                end
                if (cost_tab[d] != sum || plen_tab[d] != kept_len(n)) changed = 1;
                for (int k = 0; !changed && k < n && k + 1 < SLOTS; k++)
                    if (path_tab[d][k+1] != pend_hops[k]) changed = 1;
                if (changed) begin
                    cost_tab[d] = COST_W'(sum);
                    store_path(d, n);
                end
                return changed;
            end
            if (sum < cost_tab[d] && !path_loops) begin
                next_hop_tab[d] = pend.router_id;
                cost_tab[d]     = COST_W'(sum);
                store_path(d, n);
                return 1;
            end
            return 0;
        endfunction

        // Updates the predicted table for one accepted request and queues its result.
        function void note_request(pvrt_pkg::t_req r);
            pvrt_pkg::t_rsp rsp;
            rsp = '0;
            case (r.operation)
                pvrt_pkg::OP_CLEAR: begin
                    foreach (valid_tab[i]) valid_tab[i] = 0;
                    pend_active = 0;
                    hops_seen   = 0;
                    path_loops  = 0;
                    valid_tab[my_id]    = 1;
                    next_hop_tab[my_id] = my_id;
                    cost_tab[my_id]     = '0;
                    plen_tab[my_id]     = PLEN_W'(1);
                    path_tab[my_id][0]  = my_id;
                end
                pvrt_pkg::OP_ADD: begin
                    valid_tab[r.router_id]    = 1;
                    next_hop_tab[r.router_id] = r.router_id;
                    cost_tab[r.router_id]     = (r.link_cost >= inf_cost) ? inf_cost
                                                                          : r.link_cost;
                    plen_tab[r.router_id]     = PLEN_W'(2);
                    path_tab[r.router_id][0]  = my_id;
                    path_tab[r.router_id][1]  = r.router_id;
                end
                pvrt_pkg::OP_HDR: begin
                    pend_active = (r.path_length != 0);
                    pend        = r;
                    hops_seen   = 0;
                    path_loops  = 0;
                end
                pvrt_pkg::OP_HOP: begin
                    if (pend_active) begin
                        pend_hops[hops_seen % HOP_BUF] = r.hop_id;
                        if (r.hop_id == my_id) path_loops = 1;
                        hops_seen++;
                        if (hops_seen >= pend.path_length) begin
                            rsp.route_changed = apply_route();
                            pend_active = 0;
                        end
                    end
                end
                pvrt_pkg::OP_DOWN: begin
                    foreach (valid_tab[i])
                        if (valid_tab[i] && next_hop_tab[i] == r.router_id)
                            cost_tab[i] = inf_cost;
                end
                pvrt_pkg::OP_READ: begin
                    if (valid_tab[r.router_id]) begin
                        rsp.entry_valid       = 1;
                        rsp.entry_next_hop    = next_hop_tab[r.router_id];
                        rsp.entry_cost        = cost_tab[r.router_id];
                        rsp.entry_path_length = plen_tab[r.router_id];
                        if (r.hop_index < plen_tab[r.router_id])
                            rsp.entry_hop = path_tab[r.router_id][r.hop_index];
                    end
                end
                default: ;
            endcase
            expected_q.push_back(rsp);
        endfunction

        function void check_result(pvrt_pkg::t_rsp got);
            pvrt_pkg::t_rsp want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = expected_q.pop_front();
            if (got.route_changed !== want.route_changed
                    || got.entry_valid !== want.entry_valid
                    || got.entry_next_hop !== want.entry_next_hop
                    || got.entry_cost !== want.entry_cost
                    || got.entry_path_length !== want.entry_path_length
                    || got.entry_hop !== want.entry_hop) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch: expected chg=%0d vld=%0d nh=%0d cost=%0d",
                             want.route_changed, want.entry_valid, want.entry_next_hop,
                             want.entry_cost);
                    $display("    expected len=%0d hop=%0d",
                             want.entry_path_length, want.entry_hop);
                    $display("    got chg=%0d vld=%0d nh=%0d cost=%0d len=%0d hop=%0d",
                             got.route_changed, got.entry_valid, got.entry_next_hop,
                             got.entry_cost, got.entry_path_length, got.entry_hop);
                end
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    pvrt_pkg::t_req       i_req;
    logic                 o_strobe;
    pvrt_pkg::t_rsp       o_rsp;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COST_W-1:0]    i_cfg_data;

    route_scoreboard sb;
    int cycles;
    int idle_mode;
    int sent;

    path_vector_route_table DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock: 8 ns period.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Results cannot be held off, so every strobe is checked at once.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_result(o_rsp);
    end

    // Optional sender gap ahead of a request, depending on the phase.
    task automatic maybe_idle();
        int pct;
        int gap;
        pct = (idle_mode == 1) ? 67 : (idle_mode == 3) ? 10 : 0;
        if ($urandom_range(99) < pct) begin
            gap = $urandom_range(1, 5);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drives one request and holds it until the block takes it.
    task automatic send_request(pvrt_pkg::t_req r);
        bit taken;
        maybe_idle();
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        taken = 0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        sb.note_request(r);
        sent++;
    endtask

    // Waits until every result has come and the block has settled.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COST_W-1:0] data);
        bit done;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        done = 0;
        while (!done) begin
            @(posedge i_clk);
            done = o_cfg_ready;
        end
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic pvrt_pkg::t_req make_req(logic [OP_W-1:0] op);
        pvrt_pkg::t_req r;
        r = pvrt_pkg::t_req'({$urandom, $urandom});
        r.operation = op;
        return r;
    endfunction

    task automatic send_op(logic [OP_W-1:0] op, int rid, int dst, int lc, int ac,
                           int plen, int hop, int hix);
        pvrt_pkg::t_req r;
        r = make_req(op);
        if (rid >= 0) r.router_id = ID_W'(rid);
        if (dst >= 0) r.dest_id = ID_W'(dst);
        if (lc >= 0) r.link_cost = COST_W'(lc);
        if (ac >= 0) r.advertised_cost = COST_W'(ac);
        if (plen >= 0) r.path_length = ID_W'(plen);
        if (hop >= 0) r.hop_id = ID_W'(hop);
        if (hix >= 0) r.hop_index = ID_W'(hix);
        send_request(r);
    endtask

    // A full route advertisement: header then its hops, a few of which may name us.
    task automatic send_route(int sender, int dst, int plen, int loop_pct);
        int hop;
        send_op(pvrt_pkg::OP_HDR, sender, dst, $urandom_range(0, 300),
                $urandom_range(0, 600), plen, -1, -1);
        for (int k = 0; k < plen; k++) begin
            hop = ($urandom_range(99) < loop_pct) ? sb.my_id : $urandom_range(15);
            send_op(pvrt_pkg::OP_HOP, -1, -1, -1, -1, -1, hop, -1);
        end
    endtask

    task automatic random_item();
        int pick;
        int plen;
        pick = $urandom_range(99);
        plen = ($urandom_range(9) == 0) ? 15 : $urandom_range(1, 4);
        if (pick < 45) send_route($urandom_range(15), $urandom_range(15), plen, 8);
        else if (pick < 55) begin
            // Forced update from the current next hop of a destination.
            send_route(sb.valid_tab[pick % 16] ? sb.next_hop_tab[pick % 16] : pick % 16,
                       pick % 16, plen, 15);
        end
        else if (pick < 65)
            send_op(pvrt_pkg::OP_ADD, $urandom_range(15), -1, -1, -1, -1, -1, -1);
        else if (pick < 82)
            send_op(pvrt_pkg::OP_READ, $urandom_range(15), -1, -1, -1, -1, -1, -1);
        else if (pick < 87)
            send_op(pvrt_pkg::OP_DOWN, $urandom_range(15), -1, -1, -1, -1, -1, -1);
        else if (pick < 89) send_op(pvrt_pkg::OP_CLEAR, -1, -1, -1, -1, -1, -1, -1);
        else if (pick < 93) send_op(pvrt_pkg::OP_HOP, -1, -1, -1, -1, -1, -1, -1);
        else if (pick < 96) begin
            // Broken sequence: header cut short by another request.
            send_op(pvrt_pkg::OP_HDR, -1, -1, -1, -1, $urandom_range(2, 15), -1, -1);
            send_op(pvrt_pkg::OP_HOP, -1, -1, -1, -1, -1, -1, -1);
        end
        else send_op(OP_W'($urandom_range(6, 7)), -1, -1, -1, -1, -1, -1, -1);
    endtask

    initial begin
        int my_ids[6];
        int infs[6];
        sb          = new();
        cycles      = 0;
        sent        = 0;
        idle_mode   = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = pvrt_pkg::CFG_MY_ID;
        i_cfg_data  = '0;
        my_ids = '{3, 15, 0, 7, 15, 5};
        infs   = '{999, 1023, 1, 50, 999, 200};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: extremes, every operation and the corner cases.
        write_reg(pvrt_pkg::CFG_MY_ID, COST_W'(3));
        write_reg(pvrt_pkg::CFG_INF, COST_W'(999));
        send_op(pvrt_pkg::OP_READ, 3, -1, -1, -1, -1, -1, 0);
        send_op(pvrt_pkg::OP_CLEAR, -1, -1, -1, -1, -1, -1, -1);
        send_op(pvrt_pkg::OP_READ, 3, -1, -1, -1, -1, -1, 0);
        send_op(pvrt_pkg::OP_ADD, 15, -1, 1023, -1, -1, -1, -1);
        send_op(pvrt_pkg::OP_ADD, 0, -1, 0, -1, -1, -1, -1);
        send_op(pvrt_pkg::OP_ADD, 3, -1, 5, -1, -1, -1, -1);
        send_op(pvrt_pkg::OP_HOP, -1, -1, -1, -1, -1, 9, -1);
        send_op(pvrt_pkg::OP_HDR, 0, 9, -1, -1, 0, -1, -1);
        send_op(pvrt_pkg::OP_HOP, -1, -1, -1, -1, -1, 9, -1);
        send_route(0, 9, 15, 0);
        send_op(pvrt_pkg::OP_READ, 9, -1, -1, -1, -1, -1, 15);
        send_route(0, 9, 2, 100);
        send_route(15, 12, 1, 0);
        send_op(pvrt_pkg::OP_HDR, 0, 12, 1023, 1023, 1, -1, -1);
        send_op(pvrt_pkg::OP_HDR, 0, 12, 0, 0, 1, -1, -1);
        send_op(pvrt_pkg::OP_HOP, -1, -1, -1, -1, -1, 0, -1);
        send_op(pvrt_pkg::OP_DOWN, 0, -1, -1, -1, -1, -1, -1);
        send_op(pvrt_pkg::OP_READ, 12, -1, -1, -1, -1, -1, 1);
        send_op(3'd6, -1, -1, -1, -1, -1, -1, -1);
        send_op(3'd7, -1, -1, -1, -1, -1, -1, -1);
        send_op(pvrt_pkg::OP_READ, 0, -1, -1, -1, -1, -1, 14);

        // Random phases across register settings and sender gap patterns.
        for (int p = 0; p < 6; p++) begin
            drain();
            write_reg(pvrt_pkg::CFG_MY_ID, COST_W'(my_ids[p]));
            write_reg(pvrt_pkg::CFG_INF, COST_W'(infs[p]));
            idle_mode = p % 4;
            send_op(pvrt_pkg::OP_CLEAR, -1, -1, -1, -1, -1, -1, -1);
            for (int k = 0; k < 6; k++)
                send_op(pvrt_pkg::OP_ADD, $urandom_range(15), -1, -1, -1, -1, -1, -1);
            while (sent < 25 + (p + 1) * 150) random_item();
        end

        drain();
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
